@@ src/lr_pkg.sv @@
// Shared types and constants for the line rasterizer.
package lr_pkg;

    // Coordinate width inside the square tile.
    localparam int COORD_BITS = 6;
    // Decision term width: holds +/- 2 * (2^COORD_BITS - 1) with margin.
    localparam int ERR_BITS = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    // Line command: two endpoints.
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } line_cmd_t;

    // One emitted pixel.
    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } pixel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
    } dp_status_t;

endpackage

@@ src/lr_datapath.sv @@
// Datapath: octant reduction, decision term stepping and pixel output register.
module lr_datapath (
    input  logic               clk,
    input  lr_pkg::line_cmd_t  line_cmd,
    input  lr_pkg::dp_cmd_t    cmd,
    output lr_pkg::dp_status_t status,
    output lr_pkg::pixel_t     pixel
);
    import lr_pkg::*;

    // Walk state.
    coord_t x_reg, x_next;
    coord_t y_reg, y_next;
    coord_t cnt_reg, cnt_next;
    err_t   d_reg, d_next;
    err_t   inc_e_reg, inc_e_next;
    err_t   inc_ne_reg, inc_ne_next;
    logic   steep_reg, steep_next;
    logic   ydec_reg, ydec_next;
    pixel_t pix_reg, pix_next;

    // Set-up values derived from the incoming command.
    logic   neg_x;
    coord_t first_x, first_y, other_y;
    logic   ydown;
    coord_t abs_dx, abs_dy;
    logic   steep_c;
    coord_t major_c, minor_c;
    err_t   two_minor, two_major, major_ext;

    // Steering for one step.
    logic   minor_step;
    coord_t y_moved;

    // Reduce the command to the first octant, expressed as a start point,
    // a vertical direction, an axis swap and the major and minor lengths.
    always_comb
    begin
        neg_x   = line_cmd.end_x < line_cmd.start_x;
        first_x = neg_x ? line_cmd.end_x : line_cmd.start_x;
        first_y = neg_x ? line_cmd.end_y : line_cmd.start_y;
        other_y = neg_x ? line_cmd.start_y : line_cmd.end_y;
        ydown   = other_y < first_y;
        abs_dx  = neg_x ? (line_cmd.start_x - line_cmd.end_x)
                        : (line_cmd.end_x - line_cmd.start_x);
        abs_dy  = ydown ? (first_y - other_y) : (other_y - first_y);
        steep_c = abs_dy > abs_dx;
        major_c = steep_c ? abs_dy : abs_dx;
        minor_c = steep_c ? abs_dx : abs_dy;
        two_minor = $signed({2'b00, minor_c, 1'b0});
        two_major = $signed({2'b00, major_c, 1'b0});
        major_ext = $signed({3'b000, major_c});
    end

    // One step along the major axis; the minor axis advances on a positive term.
    always_comb
    begin
        minor_step = d_reg > err_t'(0);
        y_moved    = ydec_reg ? (y_reg - coord_t'(1)) : (y_reg + coord_t'(1));
    end

    // Next-state selection for the walk registers.
    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        cnt_next    = cnt_reg;
        d_next      = d_reg;
        inc_e_next  = inc_e_reg;
        inc_ne_next = inc_ne_reg;
        steep_next  = steep_reg;
        ydec_next   = ydec_reg;
        pix_next    = pix_reg;
        if (cmd.load)
        begin
            x_next      = first_x;
            y_next      = first_y;
            cnt_next    = major_c;
            d_next      = two_minor - major_ext;
            inc_e_next  = two_minor;
            inc_ne_next = two_minor - two_major;
            steep_next  = steep_c;
            ydec_next   = ydown;
        end
        else if (cmd.step)
        begin
            pix_next.pixel_x    = x_reg;
            pix_next.pixel_y    = y_reg;
            pix_next.last_pixel = (cnt_reg == '0);
            cnt_next = cnt_reg - coord_t'(1);
            d_next   = minor_step ? (d_reg + inc_ne_reg) : (d_reg + inc_e_reg);
            if (steep_reg)
            begin
                y_next = y_moved;
                x_next = minor_step ? (x_reg + coord_t'(1)) : x_reg;
            end
            else
            begin
                x_next = x_reg + coord_t'(1);
                y_next = minor_step ? y_moved : y_reg;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        cnt_reg    <= cnt_next;
        d_reg      <= d_next;
        inc_e_reg  <= inc_e_next;
        inc_ne_reg <= inc_ne_next;
        steep_reg  <= steep_next;
        ydec_reg   <= ydec_next;
        pix_reg    <= pix_next;
    end

    assign status.last = (cnt_reg == '0);
    assign pixel       = pix_reg;

endmodule

@@ src/lr_ctrl.sv @@
// Controller: accepts line commands and paces the pixel walk against the output.
module lr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    output lr_pkg::dp_cmd_t    cmd,
    input  lr_pkg::dp_status_t status
);
    import lr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_DRAW
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   advance;

    // A pixel moves into the output register when the register is free or
    // is being emptied in this cycle.
    assign advance  = (state_reg == ST_DRAW) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == ST_IDLE);
    assign cmd.load = (state_reg == ST_IDLE) && in_valid;
    assign cmd.step = advance;

    // Next state and output valid.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (out_ready)
                    out_valid_next = 1'b0;
                if (in_valid)
                    state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    if (status.last)
                        state_next = ST_IDLE;
                end
                else if (out_ready)
                    out_valid_next = 1'b0;
            end
            default:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/line_rasterizer.sv @@
// Top level of the line rasterizer: controller, datapath and checks.
//
// Usage: a line command (start_x, start_y, end_x, end_y) enters on the
// in_valid / in_ready channel; one transaction is taken per line. The block
// then emits every pixel of the midpoint line on the out_valid / out_ready
// channel, one transaction per pixel, with last_pixel set on the final one.
// Pixels run from the start point, or from the end point when end_x is less
// than start_x.
// The command is first loaded into the walk registers; the first pixel then
// enters the output register once that register is free. A line of n pixels
// (n = max(|dx|,|dy|) + 1, at most 64) is walked by the decision-term update
// in the datapath at one pixel per cycle while the receiver does not stall.
// A new command is taken as soon as the last pixel sits in the output
// register, even while that pixel still waits for the receiver.
// When the receiver stalls, the walk halts with the pending pixel held.
// Reset clears the controller: no pixel is pending and in_ready is high.
module line_rasterizer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lr_pkg::line_cmd_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output lr_pkg::pixel_t    out_data
);
    import lr_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Sequencing of commands and output handshake.
    lr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    // Octant reduction and pixel stepping.
    lr_datapath u_datapath (
        .clk      (clk),
        .line_cmd (in_data),
        .cmd      (dp_cmd),
        .status   (dp_status),
        .pixel    (out_data)
    );

`ifndef SYNTH
    // Input ready drops right after a command is taken, since its walk blocks the input.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a command was taken");

    // While ready for a command, only the final pixel of a line may be pending.
    a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && in_ready) |-> out_data.last_pixel)
        else $error("non-final pixel pending while idle");

    // Delivering a non-final pixel puts the next pixel of the line in its place.
    a_mid_line_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last_pixel) |=> out_valid)
        else $error("pixel stream broke in the middle of a line");
`endif

endmodule

@@ tb/line_rasterizer_tb.sv @@
// Self-checking testbench for the line rasterizer: random line commands against a pixel predictor.
`timescale 1ns / 1ps

module line_rasterizer_tb;

    import lr_pkg::*;

    // A queued line command, optionally held back until the block has drained.
    typedef struct {
        line_cmd_t cmd;
        bit        drain_first;
    } line_job_t;

    localparam int MAX_WAIT     = 18;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_LIMIT  = 200000;
    localparam int SETTLE_TAIL  = 16;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    line_cmd_t in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    pixel_t    out_data;

    line_job_t line_queue[$];
    pixel_t    pending_pixels[$];
    int        mismatch_count = 0;

    // Handshake flags captured at the rising edge, used by the drivers at the falling edge.
    logic cmd_taken = 1'b0;
    logic out_taken = 1'b0;

    int send_wait = 0;
    int send_calm = 0;
    int recv_wait = 0;
    int recv_calm = 0;

    line_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // Idle length for one transaction, with occasional stretches of back-to-back traffic.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            calm = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Midpoint line walk: appends every pixel of the line to the expected queue.
    function automatic void trace_line(line_cmd_t c);
        int     ax, ay, bx, by, dx, dy, t;
        int     err, step_flat, step_diag, major, minor, px, py;
        bit     flip_y, steep, done;
        pixel_t p;
        ax = c.start_x;
        ay = c.start_y;
        bx = c.end_x;
        by = c.end_y;
        dx = bx - ax;
        dy = by - ay;
        flip_y = 1'b0;
        // Bring the line into the first quadrant.
        if (dx < 0 && dy < 0)
        begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        else if (!(dx >= 0 && dy > 0))
        begin
            flip_y = 1'b1;
            ay = -ay;
            by = -by;
            if (dx < 0)
            begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
        end
        dx = bx - ax;
        dy = by - ay;
        // Steep lines walk along y instead of x.
        steep = (dy > dx);
        if (steep)
        begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
            dx = bx - ax;
            dy = by - ay;
        end
        err       = 2 * dy - dx;
        step_flat = 2 * dy;
        step_diag = 2 * (dy - dx);
        major     = ax;
        minor     = ay;
        done      = 1'b0;
        while (!done)
        begin
            px = steep ? minor : major;
            py = steep ? major : minor;
            if (flip_y)
                py = -py;
            done         = (major >= bx);
            p.pixel_x    = px[COORD_BITS-1:0];
            p.pixel_y    = py[COORD_BITS-1:0];
            p.last_pixel = done;
            pending_pixels.push_back(p);
            // A zero decision term keeps the minor coordinate.
            if (err <= 0)
                err += step_flat;
            else
            begin
                err += step_diag;
                minor++;
            end
            major++;
        end
    endfunction

    task automatic add_line(int sx, int sy, int ex, int ey, bit drain_first);
        line_job_t job;
        job.cmd.start_x  = sx[COORD_BITS-1:0];
        job.cmd.start_y  = sy[COORD_BITS-1:0];
        job.cmd.end_x    = ex[COORD_BITS-1:0];
        job.cmd.end_y    = ey[COORD_BITS-1:0];
        job.drain_first  = drain_first;
        line_queue.push_back(job);
    endtask

    // Command driver: presents one transaction at a time, with a random idle gap, possibly none, between them.
    always @(negedge clk)
    begin : drive_commands
        logic      next_valid;
        line_cmd_t next_cmd;
        next_valid = in_valid;
        next_cmd   = in_data;
        if (rst_n)
        begin
            if (cmd_taken)
            begin
                next_valid = 1'b0;
                send_wait  = draw_wait(send_calm);
            end
            if (!next_valid)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (line_queue.size() != 0 &&
                         !(line_queue[0].drain_first && pending_pixels.size() != 0))
                begin
                    next_cmd   = line_queue.pop_front().cmd;
                    next_valid = 1'b1;
                end
            end
        end
        in_valid <= next_valid;
        in_data  <= next_cmd;
    end

    // Pixel receiver: stalls for a random number of cycles after each transaction.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                recv_wait = draw_wait(recv_calm);
            if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: checks each pixel against the oldest expectation and predicts new lines.
    always @(posedge clk)
    begin : check_pixels
        pixel_t want;
        cmd_taken <= rst_n && in_valid && in_ready;
        out_taken <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected pixel (%0d,%0d) last=%0b with nothing expected",
                             out_data.pixel_x, out_data.pixel_y, out_data.last_pixel);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (out_data.pixel_x !== want.pixel_x || out_data.pixel_y !== want.pixel_y ||
                    out_data.last_pixel !== want.last_pixel)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("Mismatch: expected (%0d,%0d) last=%0b, got (%0d,%0d) last=%0b",
                                 want.pixel_x, want.pixel_y, want.last_pixel,
                                 out_data.pixel_x, out_data.pixel_y, out_data.last_pixel);
                end
            end
        end
        if (rst_n && in_valid && in_ready)
            trace_line(in_data);
    end

    // Stimulus and end of run.
    initial
    begin
        int kind, sx, sy, ex, ey, drain_cycles;

        // Single points, full-span axis lines and diagonals.
        add_line(0, 0, 0, 0, 1'b1);
        add_line(63, 63, 63, 63, 1'b0);
        add_line(0, 0, 63, 0, 1'b0);
        add_line(63, 63, 0, 63, 1'b0);
        add_line(0, 0, 0, 63, 1'b0);
        add_line(63, 63, 63, 0, 1'b0);
        add_line(0, 0, 63, 63, 1'b1);
        add_line(63, 63, 0, 0, 1'b0);
        add_line(0, 63, 63, 0, 1'b0);
        add_line(63, 0, 0, 63, 1'b0);
        // One line in each octant around the tile centre.
        add_line(32, 32, 40, 35, 1'b0);
        add_line(32, 32, 35, 40, 1'b0);
        add_line(32, 32, 24, 35, 1'b1);
        add_line(32, 32, 29, 40, 1'b0);
        add_line(32, 32, 24, 29, 1'b0);
        add_line(32, 32, 29, 24, 1'b0);
        add_line(32, 32, 40, 29, 1'b0);
        add_line(32, 32, 35, 24, 1'b0);
        // Midpoint ties, forwards, backwards and steep.
        add_line(0, 0, 4, 2, 1'b0);
        add_line(10, 20, 12, 21, 1'b0);
        add_line(5, 5, 1, 7, 1'b0);
        add_line(0, 0, 2, 4, 1'b0);
        // Nearly vertical and nearly horizontal full-span lines.
        add_line(0, 0, 1, 63, 1'b0);
        add_line(63, 0, 0, 1, 1'b0);

        // Random lines: arbitrary, short, and axis-aligned or diagonal.
        for (int i = 0; i < 76; i++)
        begin
            kind = $urandom_range(0, 3);
            sx   = $urandom_range(0, 63);
            sy   = $urandom_range(0, 63);
            ex   = $urandom_range(0, 63);
            ey   = $urandom_range(0, 63);
            if (kind == 1)
            begin
                ex = sx + $urandom_range(0, 16) - 8;
                ey = sy + $urandom_range(0, 16) - 8;
                ex = (ex < 0) ? 0 : ((ex > 63) ? 63 : ex);
                ey = (ey < 0) ? 0 : ((ey > 63) ? 63 : ey);
            end
            else if (kind == 2)
            begin
                case ($urandom_range(0, 2))
                    0: ey = sy;
                    1: ex = sx;
                    default:
                    begin
                        ex = ($urandom_range(0, 1) != 0) ? 63 : 0;
                        ey = sy + (($urandom_range(0, 1) != 0) ? 1 : -1) * (ex - sx);
                        if (ey < 0 || ey > 63)
                            ey = sy - (ey - sy);
                        if (ey < 0 || ey > 63)
                            ey = sy;
                    end
                endcase
            end
            add_line(sx, sy, ex, ey, (i == 0) || ($urandom_range(0, 19) == 0));
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (line_queue.size() != 0 || in_valid)
            @(posedge clk);
        drain_cycles = 0;
        while (pending_pixels.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_TAIL) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            mismatch_count++;
            $display("%0d expected pixels never arrived", pending_pixels.size());
        end

        if (mismatch_count == 0)
            $display("PASS line_rasterizer");
        else
            $display("FAIL line_rasterizer");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4000000;
        $display("FAIL line_rasterizer");
        $finish;
    end

endmodule

@@ filelist.f @@
src/lr_pkg.sv
src/lr_datapath.sv
src/lr_ctrl.sv
src/line_rasterizer.sv
tb/line_rasterizer_tb.sv
